// ----- sv/rotenc_pkg.sv -----
`default_nettype none
package rotenc_pkg;

  localparam int TIME_BITS = 32;
  localparam int DEB_BITS  = 16;
  localparam int SPD_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int SAT_BITS  = 5;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic signed [SAT_BITS-1:0] sat_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_CLICK = 3'd3,
    EV_LONG  = 3'd4
  } ev_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_LONG      = 2'd1,
    REG_FAST      = 2'd2,
    REG_SPD       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DEB_BITS-1:0] debounce_periods;
    time_t               long_press_periods;
    time_t               fast_turn_periods;
    logic [SPD_BITS-1:0] steps_per_detent;
  } cfg_t;

  // quadrature step from {previous pair, current pair}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic sat_t sat5(input logic signed [SAT_BITS:0] v);
    sat_t r;
    if (v > 6'sd15) begin
      r = 5'sd15;
    end else if (v < -6'sd16) begin
      r = -5'sd16;
    end else begin
      r = v[SAT_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rotary_encoder_with_button.sv -----
`default_nettype none
// Rotary encoder and push-button decoder, one sample word per sample period.
//
// Input channel: phase_a, phase_b, button_level (0 = pressed), taken when
// in_valid is high and in_stall is low. Output channel: event_res
// (none / cw / ccw / click / long click) and fast_turn, one word per input
// word, taken when out_valid is high and out_stall is low.
// Config channel: cfg_index selects debounce, long press, fast turn or
// steps per detent; cfg_ready is always high. Write only while idle.
//
// A taken word is held in the input register; its result is registered in the
// output register as the word advances. Throughput is one word per cycle
// while the output is not stalled; the whole step is one pass of logic between
// the two registers, with all decoder state updated as the result is registered.
// When out_stall holds the result, the input register still takes one more
// word, after which in_stall rises until the output drains.
// Reset (rst, synchronous) empties both registers and restores the
// register defaults and the decoder state.
module rotary_encoder_with_button (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 phase_a,
  input  wire logic                                 phase_b,
  input  wire logic                                 button_level,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [2:0]                                event_res,
  output logic                                      fast_turn,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rotenc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [rotenc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  rotenc_pkg::cfg_t cfg;
  rotenc_pkg::ev_t  ev_next;
  logic             fast_next;
  logic             s_valid, s_a, s_b, s_btn;
  logic             adv;

  assign adv      = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !adv;

  rotenc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rotenc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .a         (s_a),
    .b         (s_b),
    .btn       (s_btn),
    .cfg       (cfg),
    .ev_next   (ev_next),
    .fast_next (fast_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_a   <= phase_a;
      s_b   <= phase_b;
      s_btn <= button_level;
    end
    if (adv) begin
      event_res <= ev_next;
      fast_turn <= fast_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rotenc_cfg.sv -----
`default_nettype none
module rotenc_cfg (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rotenc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [rotenc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output rotenc_pkg::cfg_t                           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_periods   <= rotenc_pkg::DEB_BITS'(20);
      cfg.long_press_periods <= rotenc_pkg::TIME_BITS'(800);
      cfg.fast_turn_periods  <= rotenc_pkg::TIME_BITS'(50);
      cfg.steps_per_detent   <= rotenc_pkg::SPD_BITS'(4);
    end else if (cfg_valid) begin
      unique case (rotenc_pkg::reg_idx_t'(cfg_index))
        rotenc_pkg::REG_DEBOUNCE:
          cfg.debounce_periods <= cfg_data[rotenc_pkg::DEB_BITS-1:0];
        rotenc_pkg::REG_LONG:
          cfg.long_press_periods <= cfg_data[rotenc_pkg::TIME_BITS-1:0];
        rotenc_pkg::REG_FAST:
          cfg.fast_turn_periods <= cfg_data[rotenc_pkg::TIME_BITS-1:0];
        rotenc_pkg::REG_SPD:
          cfg.steps_per_detent <= cfg_data[rotenc_pkg::SPD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/rotenc_step.sv -----
`default_nettype none
module rotenc_step (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             a,
  input  wire logic             b,
  input  wire logic             btn,
  input  wire rotenc_pkg::cfg_t cfg,
  output rotenc_pkg::ev_t       ev_next,
  output logic                  fast_next
);

  logic [1:0]        prev_phases;
  rotenc_pkg::sat_t  pending_delta, pending_delta_next;
  rotenc_pkg::sat_t  detent_accum, detent_accum_next;
  rotenc_pkg::time_t period_count;
  rotenc_pkg::time_t last_detent_time, last_detent_time_next;
  logic              fast_flag;
  logic              last_raw_button;
  logic              stable_button, stable_button_next;
  rotenc_pkg::time_t last_edge_time, last_edge_time_next;
  logic              press_pending, press_pending_next;
  rotenc_pkg::time_t press_time, press_time_next;

  rotenc_pkg::sat_t  pd1, acc1;
  rotenc_pkg::ev_t   btn_ev;
  rotenc_pkg::time_t edge_age, hold_age, detent_age;
  logic signed [rotenc_pkg::SAT_BITS:0] spd, acc_up, acc_dn;
  logic [rotenc_pkg::SPD_BITS-1:0] spd_raw;

  assign edge_age   = period_count - last_edge_time;
  assign hold_age   = period_count - press_time;
  assign detent_age = period_count - last_detent_time;
  assign spd_raw    = (cfg.steps_per_detent == '0) ? rotenc_pkg::SPD_BITS'(1)
                                                   : cfg.steps_per_detent;
  assign spd        = $signed({2'b00, spd_raw});

  always_comb begin
    pd1 = rotenc_pkg::sat5(6'(pending_delta) + 6'(rotenc_pkg::quad_step({prev_phases, a, b})));

    // button debounce and click classification
    btn_ev              = rotenc_pkg::EV_NONE;
    last_edge_time_next = last_edge_time;
    stable_button_next  = stable_button;
    press_pending_next  = press_pending;
    press_time_next     = press_time;
    if (btn != last_raw_button) begin
      last_edge_time_next = period_count;
    end else if (edge_age >= rotenc_pkg::TIME_BITS'(cfg.debounce_periods)
                 && btn != stable_button) begin
      stable_button_next = btn;
      if (!btn) begin
        press_time_next    = period_count;
        press_pending_next = 1'b1;
      end else if (press_pending) begin
        press_pending_next = 1'b0;
        btn_ev = (hold_age >= cfg.long_press_periods) ? rotenc_pkg::EV_LONG
                                                      : rotenc_pkg::EV_CLICK;
      end
    end

    // rotation, only when the button gave nothing
    acc1   = rotenc_pkg::sat5(6'(detent_accum) + 6'(pd1));
    acc_up = 6'(acc1) - spd;
    acc_dn = 6'(acc1) + spd;
    ev_next               = btn_ev;
    pending_delta_next    = pd1;
    detent_accum_next     = detent_accum;
    last_detent_time_next = last_detent_time;
    fast_next             = fast_flag;
    if (btn_ev == rotenc_pkg::EV_NONE) begin
      pending_delta_next = '0;
      if (!stable_button_next || press_pending_next) begin
        detent_accum_next = '0;
      end else if (6'(acc1) >= spd) begin
        detent_accum_next     = acc_up[rotenc_pkg::SAT_BITS-1:0];
        ev_next               = rotenc_pkg::EV_CW;
        fast_next             = detent_age < cfg.fast_turn_periods;
        last_detent_time_next = period_count;
      end else if (6'(acc1) <= -spd) begin
        detent_accum_next     = acc_dn[rotenc_pkg::SAT_BITS-1:0];
        ev_next               = rotenc_pkg::EV_CCW;
        fast_next             = detent_age < cfg.fast_turn_periods;
        last_detent_time_next = period_count;
      end else begin
        detent_accum_next = acc1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phases      <= 2'b11;
      pending_delta    <= '0;
      detent_accum     <= '0;
      period_count     <= '0;
      last_detent_time <= '0;
      fast_flag        <= 1'b0;
      last_raw_button  <= 1'b1;
      stable_button    <= 1'b1;
      last_edge_time   <= '0;
      press_pending    <= 1'b0;
      press_time       <= '0;
    end else if (en) begin
      prev_phases      <= {a, b};
      pending_delta    <= pending_delta_next;
      detent_accum     <= detent_accum_next;
      period_count     <= period_count + 1'b1;
      last_detent_time <= last_detent_time_next;
      fast_flag        <= fast_next;
      last_raw_button  <= btn;
      stable_button    <= stable_button_next;
      last_edge_time   <= last_edge_time_next;
      press_pending    <= press_pending_next;
      press_time       <= press_time_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rotenc_checker.sv -----
`default_nettype none
module rotenc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] event_res,
  input wire logic       fast_turn
);

  // held word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(fast_turn))
    else $error("output word changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= rotenc_pkg::EV_LONG)
    else $error("event code out of range");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("channels not empty after reset");

  // input only backs up behind a full output register
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind rotary_encoder_with_button rotenc_checker u_rotenc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .event_res (event_res),
  .fast_turn (fast_turn)
);
`default_nettype wire

// ----- verif/tb_rotary_encoder_with_button.sv -----
`default_nettype none
module tb_rotary_encoder_with_button;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;

  // step direction indexed by {previous pair, current pair}
  localparam int QUAD_DIR [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // next phase pair for one step in each direction
  localparam logic [1:0] CW_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] CCW_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  // walk that covers all sixteen phase transitions, starting from the reset pair
  localparam logic [1:0] WALK [16] = '{2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3,
                                       2'd1, 2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    logic a;
    logic b;
    logic btn;
  } sample_t;

  typedef struct packed {
    rotenc_pkg::ev_t ev;
    logic            fast;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic phase_a = 1'b1;
  logic phase_b = 1'b1;
  logic button_level = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] event_res;
  logic fast_turn;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rotenc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [rotenc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  rotary_encoder_with_button dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .phase_a(phase_a),
    .phase_b(phase_b),
    .button_level(button_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .fast_turn(fast_turn),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  sample_t  pending_samples[$];
  outcome_t expected_outcomes[$];

  int words_pending = 0;
  int words_pushed = 0;
  int results_seen = 0;
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_done = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  // stimulus generator position
  logic [1:0] gen_ph = 2'd3;
  logic       gen_btn = 1'b1;

  // decoder settings as the block should hold them
  logic [rotenc_pkg::DEB_BITS-1:0] set_debounce;
  rotenc_pkg::time_t               set_long;
  rotenc_pkg::time_t               set_fast;
  logic [rotenc_pkg::SPD_BITS-1:0] set_steps;

  // decoder state
  logic [1:0]        ph_prev;
  rotenc_pkg::sat_t  step_sum;
  rotenc_pkg::sat_t  detent_sum;
  rotenc_pkg::time_t sample_time;
  rotenc_pkg::time_t last_detent_at;
  logic              fast_now;
  logic              btn_raw;
  logic              btn_stable;
  rotenc_pkg::time_t btn_edge_at;
  logic              held;
  rotenc_pkg::time_t held_since;

  function automatic void decoder_reset();
    set_debounce = 16'd20;
    set_long = 32'd800;
    set_fast = 32'd50;
    set_steps = 4'd4;
    ph_prev = 2'd3;
    step_sum = '0;
    detent_sum = '0;
    sample_time = '0;
    last_detent_at = '0;
    fast_now = 1'b0;
    btn_raw = 1'b1;
    btn_stable = 1'b1;
    btn_edge_at = '0;
    held = 1'b0;
    held_since = '0;
  endfunction

  function automatic void apply_reg(input rotenc_pkg::reg_idx_t idx, input logic [31:0] val);
    case (idx)
      rotenc_pkg::REG_DEBOUNCE: set_debounce = val[rotenc_pkg::DEB_BITS-1:0];
      rotenc_pkg::REG_LONG:     set_long = val;
      rotenc_pkg::REG_FAST:     set_fast = val;
      rotenc_pkg::REG_SPD:      set_steps = val[rotenc_pkg::SPD_BITS-1:0];
      default:                  ;
    endcase
  endfunction

  function automatic rotenc_pkg::sat_t clamp_count(input int v);
    if (v > 15) return rotenc_pkg::sat_t'(15);
    if (v < -16) return rotenc_pkg::sat_t'(-16);
    return rotenc_pkg::sat_t'(v);
  endfunction

  function automatic void decode_sample(input logic a, input logic b, input logic btn,
                                        output rotenc_pkg::ev_t ev, output logic fast);
    logic [1:0] cur;
    int d;
    int acc;
    int spd;
    cur = {a, b};
    step_sum = clamp_count(int'(step_sum) + QUAD_DIR[{ph_prev, cur}]);
    ph_prev = cur;
    ev = rotenc_pkg::EV_NONE;

    // button debounce and click classification
    if (btn != btn_raw) begin
      btn_raw = btn;
      btn_edge_at = sample_time;
    end else if ((sample_time - btn_edge_at) >= set_debounce && btn != btn_stable) begin
      btn_stable = btn;
      if (!btn) begin
        held_since = sample_time;
        held = 1'b1;
      end else if (held) begin
        held = 1'b0;
        ev = ((sample_time - held_since) >= set_long) ? rotenc_pkg::EV_LONG
                                                      : rotenc_pkg::EV_CLICK;
      end
    end

    // rotation is skipped on a button event; the step count waits
    if (ev == rotenc_pkg::EV_NONE) begin
      d = int'(step_sum);
      step_sum = '0;
      if (!btn_stable || held) begin
        detent_sum = '0;
      end else begin
        spd = (set_steps == 0) ? 1 : int'(set_steps);
        acc = int'(clamp_count(int'(detent_sum) + d));
        if (acc >= spd) begin
          acc = acc - spd;
          ev = rotenc_pkg::EV_CW;
        end else if (acc <= -spd) begin
          acc = acc + spd;
          ev = rotenc_pkg::EV_CCW;
        end
        detent_sum = rotenc_pkg::sat_t'(acc);
        if (ev != rotenc_pkg::EV_NONE) begin
          fast_now = ((sample_time - last_detent_at) < set_fast);
          last_detent_at = sample_time;
        end
      end
    end
    sample_time = sample_time + 1;
    fast = fast_now;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  // input driver
  always @(posedge clk) begin : driver
    sample_t nxt;
    rotenc_pkg::ev_t ev;
    logic ft;
    logic nv;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_sample(phase_a, phase_b, button_level, ev, ft);
        expected_outcomes.push_back('{ev, ft});
        words_pending--;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          nxt = pending_samples.pop_front();
          phase_a <= nxt.a;
          phase_b <= nxt.b;
          button_level <= nxt.btn;
          nv = 1'b1;
          gap_left = burst_mode ? 0 : $urandom_range(0, 3);
        end
      end
    end
    in_valid <= nv;
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin : monitor
    outcome_t want;
    logic st;
    st = 1'b0;
    if (rst) begin
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          flag_mismatch("unexpected word, event", int'(event_res), -1);
        end else begin
          want = expected_outcomes.pop_front();
          if (event_res !== want.ev) begin
            flag_mismatch("event", int'(event_res), int'(want.ev));
          end
          if (fast_turn !== want.fast) begin
            flag_mismatch("fast_turn", int'(fast_turn), int'(want.fast));
          end
        end
        results_seen++;
        stall_left = burst_mode ? 0 : $urandom_range(0, 3);
      end
      if (hold_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_done = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end
    end
    out_stall <= st;
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL rotary_encoder_with_button");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] ph, input logic btn);
    pending_samples.push_back('{ph[1], ph[0], btn});
    words_pending++;
    words_pushed++;
    gen_ph = ph;
    gen_btn = btn;
  endtask

  task automatic rest(input int n, input logic btn);
    repeat (n) push_word(gen_ph, btn);
  endtask

  task automatic turn(input int steps, input bit cw, input int dwell_max);
    logic [1:0] ph;
    repeat (steps) begin
      ph = cw ? CW_NEXT[gen_ph] : CCW_NEXT[gen_ph];
      repeat ($urandom_range(1, dwell_max)) push_word(ph, gen_btn);
    end
  endtask

  // press and release with contact bounce, hold length spread around the thresholds
  task automatic gen_press(input bit turning);
    int dcap;
    int lcap;
    int hold;
    int tail;
    dcap = (set_debounce > 40) ? 40 : int'(set_debounce);
    lcap = (set_long > 60) ? 60 : int'(set_long);
    case ($urandom_range(0, 3))
      0: hold = $urandom_range(1, dcap + 1);
      1: hold = dcap + $urandom_range(1, 4);
      2: hold = dcap + lcap + $urandom_range(0, 4) - 1;
      default: hold = $urandom_range(1, dcap + lcap + 8);
    endcase
    if (hold < 1) hold = 1;
    repeat ($urandom_range(0, 2)) begin
      rest(1, 1'b0);
      rest(1, 1'b1);
    end
    for (int i = 0; i < hold; i++) begin
      if (turning && $urandom_range(0, 2) == 0) begin
        gen_btn = 1'b0;
        turn(1, 1'($urandom_range(0, 1)), 1);
      end else begin
        rest(1, 1'b0);
      end
    end
    repeat ($urandom_range(0, 2)) begin
      rest(1, 1'b1);
      rest(1, 1'b0);
    end
    tail = dcap + 1 + $urandom_range(0, 3);
    for (int i = 0; i < tail; i++) begin
      if (turning && $urandom_range(0, 2) == 0) begin
        gen_btn = 1'b1;
        turn(1, 1'($urandom_range(0, 1)), 1);
      end else begin
        rest(1, 1'b1);
      end
    end
  endtask

  task automatic gen_mix(input int n);
    int stop;
    stop = words_pushed + n;
    while (words_pushed < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          gen_btn = 1'b1;
          turn($urandom_range(1, 16), 1'($urandom_range(0, 1)), $urandom_range(1, 4));
        end
        4: rest($urandom_range(1, 30), 1'b1);
        5, 6: gen_press(1'($urandom_range(0, 1)));
        7: gen_press(1'b1);
        8: repeat ($urandom_range(1, 6)) push_word(2'($urandom), 1'($urandom));
        default: begin
          // dither back and forth across one edge
          turn(1, 1'b1, 1);
          turn(1, 1'b0, 1);
        end
      endcase
    end
  endtask

  // wait until every word is through and the block is idle
  task automatic settle();
    while (words_pending != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input rotenc_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic program_regs(input logic [15:0] deb, input logic [31:0] long_p,
                              input logic [31:0] fast_p, input logic [3:0] spd);
    write_reg(rotenc_pkg::REG_DEBOUNCE, {16'($urandom), deb});
    write_reg(rotenc_pkg::REG_LONG, long_p);
    write_reg(rotenc_pkg::REG_FAST, fast_p);
    write_reg(rotenc_pkg::REG_SPD, {28'($urandom), spd});
  endtask

  initial begin
    decoder_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all phase transitions, button chattering then released
    for (int i = 0; i < 16; i++) push_word(WALK[i], (i < 8) ? 1'(i) : 1'b1);
    gen_mix(80);

    // zero debounce and zero steps per detent: click, long click, single-step detents
    settle();
    program_regs(16'd0, 32'd3, 32'hFFFF_FFFF, 4'd0);
    rest(2, 1'b0);
    rest(2, 1'b1);
    rest(5, 1'b0);
    rest(2, 1'b1);
    turn(2, 1'b1, 1);
    turn(2, 1'b0, 1);

    settle();
    program_regs(16'd0, 32'd0, 32'd0, 4'd1);
    gen_mix(100);

    settle();
    program_regs(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    gen_mix(60);

    for (int p = 0; p < 7; p++) begin
      settle();
      burst_mode = (p == 2 || p == 5);
      program_regs(16'($urandom_range(0, 8)), $urandom_range(0, 40),
                   $urandom_range(0, 24), 4'($urandom_range(0, 5)));
      if (p == 1 || p == 4) hold_requests++;
      gen_mix(85);
    end

    settle();
    if (errors == 0) begin
      $display("PASS rotary_encoder_with_button");
    end else begin
      $display("FAIL rotary_encoder_with_button");
    end
    $finish;
  end

endmodule
`default_nettype wire
